// ===== hw/rtl/blwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package blwd_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

endpackage
`default_nettype wire

// ===== hw/rtl/blwd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module blwd_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_list_with_dedup_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake                | Payload
// command  | start, busy              | command, value, range_start, range_end
// config   | cfg_valid, cfg_ready     | cfg_data (allow_duplicates)
// result   | result_valid (strobe)    | status, has_value, element_value, last, entry_count
//
// Full appends, empty ranges and the unused code put their result out in the cycle after
// acceptance and keep busy low; an append with duplicates allowed answers from the scan state
// without a read. Other commands walk the entry memory one entry per cycle behind its
// registered read, for a duplicate check, a remove or a range read, whose results come
// one per cycle.
// Reset clears the count and sets allow_duplicates; the receiver cannot stall results.
module bounded_list_with_dedup_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic signed [blwd_pkg::DATA_W-1:0] value,
  input  wire logic [blwd_pkg::CNT_W-1:0]    range_start,
  input  wire logic [blwd_pkg::CNT_W-1:0]    range_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data,
  output logic                               result_valid,
  output logic [1:0]                         status,
  output logic                               has_value,
  output logic signed [blwd_pkg::DATA_W-1:0] element_value,
  output logic                               last,
  output logic [blwd_pkg::CNT_W-1:0]         entry_count
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                         state;
  logic [1:0]                     op;
  logic [blwd_pkg::DATA_W-1:0]    value_q;
  logic [blwd_pkg::CNT_W-1:0]     count;
  logic [blwd_pkg::CNT_W-1:0]     rd_addr;
  logic [blwd_pkg::CNT_W-1:0]     limit;
  logic [blwd_pkg::CNT_W-1:0]     wptr;
  logic                           pend;
  logic                           pend_last;
  logic                           found;
  logic                           allow_dup;

  logic                           we;
  logic [blwd_pkg::IDX_W-1:0]     waddr;
  logic [blwd_pkg::DATA_W-1:0]    wdata;
  logic [blwd_pkg::DATA_W-1:0]    rdata;
  logic                           issue;
  logic                           finish;
  logic                           hit;
  logic [blwd_pkg::CNT_W-1:0]     read_end;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  assign issue    = (state == ST_SCAN) && (rd_addr < limit);
  assign finish   = (state == ST_SCAN) && !pend && (rd_addr == limit);
  assign hit      = (rdata == value_q);
  assign read_end = (range_end > count) ? count : range_end;

  // Compaction writes behind the read pointer, so a write never meets the
  // entry being fetched in the same cycle.
  always_comb begin
    we    = 1'b0;
    waddr = wptr[blwd_pkg::IDX_W-1:0];
    wdata = rdata;
    if (state == ST_SCAN) begin
      if (op == blwd_pkg::CMD_APPEND) begin
        we    = finish && !found;
        waddr = count[blwd_pkg::IDX_W-1:0];
        wdata = value_q;
      end else if (op == blwd_pkg::CMD_REMOVE) begin
        we = pend && !hit;
      end
    end
  end

  blwd_ram #(
    .DEPTH  (blwd_pkg::CAPACITY),
    .WIDTH  (blwd_pkg::DATA_W),
    .ADDR_W (blwd_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr[blwd_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      allow_dup    <= 1'b1;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pend         <= issue;
      pend_last    <= (rd_addr + blwd_pkg::CNT_W'(1)) == limit;
      if (issue) begin
        rd_addr <= rd_addr + blwd_pkg::CNT_W'(1);
      end

      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            allow_dup <= cfg_data;
          end
          if (start) begin
            op            <= command;
            value_q       <= value;
            found         <= 1'b0;
            wptr          <= '0;
            rd_addr       <= '0;
            status        <= blwd_pkg::STAT_DONE;
            has_value     <= 1'b0;
            element_value <= '0;
            last          <= 1'b1;
            entry_count   <= count;
            unique case (command)
              blwd_pkg::CMD_APPEND: begin
                if (count >= blwd_pkg::CAP_COUNT) begin
                  status       <= blwd_pkg::STAT_FULL;
                  result_valid <= 1'b1;
                end else begin
                  limit <= allow_dup ? '0 : count;
                  state <= ST_SCAN;
                end
              end
              blwd_pkg::CMD_REMOVE: begin
                limit <= count;
                state <= ST_SCAN;
              end
              blwd_pkg::CMD_READ: begin
                if ((range_start < range_end) && (range_start < count)) begin
                  rd_addr <= range_start;
                  limit   <= read_end;
                  state   <= ST_SCAN;
                end else begin
                  result_valid <= 1'b1;
                end
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (pend) begin
            case (op)
              blwd_pkg::CMD_APPEND: begin
                if (hit) begin
                  found <= 1'b1;
                end
              end
              blwd_pkg::CMD_REMOVE: begin
                if (hit) begin
                  found <= 1'b1;
                end else begin
                  wptr <= wptr + blwd_pkg::CNT_W'(1);
                end
              end
              default: begin
                result_valid  <= 1'b1;
                status        <= blwd_pkg::STAT_DONE;
                has_value     <= 1'b1;
                element_value <= rdata;
                last          <= pend_last;
                entry_count   <= count;
              end
            endcase
          end
          if (finish) begin
            state <= ST_IDLE;
            case (op)
              blwd_pkg::CMD_APPEND: begin
                result_valid  <= 1'b1;
                has_value     <= 1'b0;
                element_value <= '0;
                last          <= 1'b1;
                if (found) begin
                  status      <= blwd_pkg::STAT_DUPLICATE;
                  entry_count <= count;
                end else begin
                  status      <= blwd_pkg::STAT_DONE;
                  count       <= count + blwd_pkg::CNT_W'(1);
                  entry_count <= count + blwd_pkg::CNT_W'(1);
                end
              end
              blwd_pkg::CMD_REMOVE: begin
                result_valid  <= 1'b1;
                has_value     <= 1'b0;
                element_value <= '0;
                last          <= 1'b1;
                status        <= found ? blwd_pkg::STAT_DONE : blwd_pkg::STAT_NOT_FOUND;
                count         <= wptr;
                entry_count   <= wptr;
              end
              default: begin
              end
            endcase
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/list_checker.sv =====
`timescale 1ns / 1ps
module list_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    command,
  input  logic signed [blwd_pkg::DATA_W-1:0] value,
  input  logic [blwd_pkg::CNT_W-1:0]    range_start,
  input  logic [blwd_pkg::CNT_W-1:0]    range_end,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,
  input  logic                          result_valid,
  input  logic [1:0]                    status,
  input  logic                          has_value,
  input  logic signed [blwd_pkg::DATA_W-1:0] element_value,
  input  logic                          last,
  input  logic [blwd_pkg::CNT_W-1:0]    entry_count,
  output int                            pending,
  output int                            mismatches
);

  typedef struct packed {
    logic [1:0]                         status;
    logic                               has_value;
    logic signed [blwd_pkg::DATA_W-1:0] element_value;
    logic                               last;
    logic [blwd_pkg::CNT_W-1:0]         entry_count;
  } list_reply_t;

  logic signed [blwd_pkg::DATA_W-1:0] shadow_list [blwd_pkg::CAPACITY];
  int                                 held;
  logic                               dup_ok;
  list_reply_t                        awaited [$];

  function automatic void push_reply(input logic [1:0] st, input logic hv,
                                     input logic signed [blwd_pkg::DATA_W-1:0] ev,
                                     input logic lst);
    list_reply_t r;
    r.status        = st;
    r.has_value     = hv;
    r.element_value = ev;
    r.last          = lst;
    r.entry_count   = blwd_pkg::CNT_W'(held);
    awaited.push_back(r);
  endfunction

  // Updates the shadow list for one accepted item and queues its replies.
  task automatic model_command(input logic [1:0] cmd,
                               input logic signed [blwd_pkg::DATA_W-1:0] val,
                               input logic [blwd_pkg::CNT_W-1:0] rs,
                               input logic [blwd_pkg::CNT_W-1:0] re);
    logic [1:0] st;
    logic       seen;
    int         w;
    int         stop;
    int         n;
    case (cmd)
      blwd_pkg::CMD_APPEND: begin
        seen = 1'b0;
        for (int i = 0; i < held; i++)
          if (shadow_list[i] == val) seen = 1'b1;
        st = blwd_pkg::STAT_DONE;
        if (held >= blwd_pkg::CAPACITY) begin
          st = blwd_pkg::STAT_FULL;
        end else if (!dup_ok && seen) begin
          st = blwd_pkg::STAT_DUPLICATE;
        end else begin
          shadow_list[held] = val;
          held++;
        end
        push_reply(st, 1'b0, '0, 1'b1);
      end
      blwd_pkg::CMD_REMOVE: begin
        seen = 1'b0;
        w = 0;
        for (int i = 0; i < held; i++) begin
          if (shadow_list[i] == val) begin
            seen = 1'b1;
          end else begin
            shadow_list[w] = shadow_list[i];
            w++;
          end
        end
        held = w;
        push_reply(seen ? blwd_pkg::STAT_DONE : blwd_pkg::STAT_NOT_FOUND, 1'b0, '0, 1'b1);
      end
      blwd_pkg::CMD_READ: begin
        n = 0;
        if (rs < re) begin
          stop = (int'(re) > held) ? held : int'(re);
          for (int i = int'(rs); i < stop; i++) begin
            push_reply(blwd_pkg::STAT_DONE, 1'b1, shadow_list[i], (i + 1 == stop));
            n++;
          end
        end
        if (n == 0) push_reply(blwd_pkg::STAT_DONE, 1'b0, '0, 1'b1);
      end
      default: begin
        push_reply(blwd_pkg::STAT_DONE, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are compared before a new item is modeled: a result seen at the
  // same edge as an acceptance belongs to the item before it.
  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      held       = 0;
      dup_ok     = 1'b1;
      mismatches = 0;
      awaited.delete();
    end else begin
      if (result_valid) begin
        if (awaited.size() == 0) begin
          $error("result with nothing expected: status %0d, element_value %0d",
                 status, element_value);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("status", longint'(want.status), longint'(status));
          check_field("has_value", longint'(want.has_value), longint'(has_value));
          check_field("element_value", longint'(want.element_value),
                      longint'(element_value));
          check_field("last", longint'(want.last), longint'(last));
          check_field("entry_count", longint'(want.entry_count), longint'(entry_count));
        end
      end
      if (cfg_valid && cfg_ready) dup_ok = cfg_data;
      if (start && !busy) model_command(command, value, range_start, range_end);
    end
    pending = awaited.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 200000;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic [1:0]                         command;
  logic signed [blwd_pkg::DATA_W-1:0] value;
  logic [blwd_pkg::CNT_W-1:0]         range_start;
  logic [blwd_pkg::CNT_W-1:0]         range_end;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic                               cfg_data;
  logic                               result_valid;
  logic [1:0]                         status;
  logic                               has_value;
  logic signed [blwd_pkg::DATA_W-1:0] element_value;
  logic                               last;
  logic [blwd_pkg::CNT_W-1:0]         entry_count;
  int                                 pending;
  int                                 mismatches;
  int                                 cycles = 0;
  int                                 gap_pct;
  logic signed [blwd_pkg::DATA_W-1:0] pool [8];

  bounded_list_with_dedup_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value), .range_start(range_start), .range_end(range_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .status(status), .has_value(has_value),
    .element_value(element_value), .last(last), .entry_count(entry_count)
  );

  list_checker list_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value), .range_start(range_start), .range_end(range_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .status(status), .has_value(has_value),
    .element_value(element_value), .last(last), .entry_count(entry_count),
    .pending(pending), .mismatches(mismatches)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(input logic [1:0] cmd,
                       input logic signed [blwd_pkg::DATA_W-1:0] val,
                       input logic [blwd_pkg::CNT_W-1:0] rs,
                       input logic [blwd_pkg::CNT_W-1:0] re);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    value       <= val;
    range_start <= rs;
    range_end   <= re;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_dup_mode(input logic allow);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= allow;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [blwd_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 80) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // The pool keeps appends and removes colliding so duplicates and hits occur.
  task automatic run_phase(input int items, input int append_pct, input int remove_pct);
    int                         r;
    int                         span;
    logic [blwd_pkg::CNT_W-1:0] rs;
    logic [blwd_pkg::CNT_W-1:0] re;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        issue(blwd_pkg::CMD_NOP, $urandom, blwd_pkg::CNT_W'($urandom),
              blwd_pkg::CNT_W'($urandom));
      end else if (r < 3 + append_pct) begin
        issue(blwd_pkg::CMD_APPEND, pick_value(), blwd_pkg::CNT_W'($urandom),
              blwd_pkg::CNT_W'($urandom));
      end else if (r < 3 + append_pct + remove_pct) begin
        issue(blwd_pkg::CMD_REMOVE, pick_value(), blwd_pkg::CNT_W'($urandom),
              blwd_pkg::CNT_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        rs = (r < 60) ? blwd_pkg::CNT_W'($urandom_range(0, 12)) :
             (r < 90) ? blwd_pkg::CNT_W'($urandom_range(0, 40)) :
                        blwd_pkg::CNT_W'($urandom_range(0, 64));
        r = $urandom_range(0, 99);
        span = int'(rs) + int'($urandom_range(0, 10));
        if (span > 64) span = 64;
        re = (r < 50) ? blwd_pkg::CNT_W'(span) :
             (r < 90) ? blwd_pkg::CNT_W'($urandom_range(0, 64)) : 7'd64;
        issue(blwd_pkg::CMD_READ, $urandom, rs, re);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    command     = blwd_pkg::CMD_APPEND;
    value       = '0;
    range_start = '0;
    range_end   = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    gap_pct     = 23;
    pool[0]     = 32'sh8000_0000;
    pool[1]     = 32'sh7fff_ffff;
    pool[2]     = 0;
    pool[3]     = -1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, value extremes, adjacent matches, range edge cases.
    issue(blwd_pkg::CMD_READ, 0, 7'd0, 7'd64);
    issue(blwd_pkg::CMD_REMOVE, 7, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_NOP, -1, 7'd127, 7'd127);
    issue(blwd_pkg::CMD_APPEND, 32'sh8000_0000, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 32'sh7fff_ffff, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 0, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, -1, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 5, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 5, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 5, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 32'sh7fff_ffff, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_READ, 0, 7'd0, 7'd64);
    issue(blwd_pkg::CMD_READ, 0, 7'd2, 7'd4);
    issue(blwd_pkg::CMD_READ, 0, 7'd5, 7'd5);
    issue(blwd_pkg::CMD_READ, 0, 7'd7, 7'd3);
    issue(blwd_pkg::CMD_READ, 0, 7'd8, 7'd64);
    issue(blwd_pkg::CMD_READ, 0, 7'd64, 7'd64);
    issue(blwd_pkg::CMD_REMOVE, 5, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_REMOVE, 32'sh7fff_ffff, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_REMOVE, 123, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_READ, 0, 7'd0, 7'd1);
    set_dup_mode(1'b0);
    issue(blwd_pkg::CMD_APPEND, -1, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_APPEND, 9, 7'd0, 7'd0);
    issue(blwd_pkg::CMD_READ, 0, 7'd0, 7'd64);

    // Fill up, then reject while full with duplicates disallowed.
    set_dup_mode(1'b1);
    run_phase(55, 90, 0);
    set_dup_mode(1'b0);
    run_phase(45, 40, 25);
    set_dup_mode(1'b1);
    gap_pct = 0;
    run_phase(50, 45, 20);
    set_dup_mode(1'b0);
    gap_pct = 23;
    run_phase(50, 45, 25);

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
